@@ design/rapx_pkg.sv @@
// Shared types, widths and codes for the rational approximation search core.
package rapx_pkg;

    localparam int IN_W      = 64;
    localparam int FRAC_BITS = 32;
    localparam int IP_W      = IN_W - FRAC_BITS;
    localparam int F_W       = 32;
    localparam int TOL_W     = 32;
    localparam int LIM_W     = 16;
    localparam int D_W       = F_W + 1;
    localparam int E_W       = 2 * F_W + 2;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 31;
    localparam int ST_W      = 2;
    localparam int PROD_W    = 2 * DEN_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET   = 32'd42950;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd4096;

    typedef logic [ST_W-1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_LIMIT = 2'd1;
    localparam t_status ST_SAT   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEG,
        S_CLASS,
        S_SUMP,
        S_SUMN,
        S_MUL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [TOL_W-1:0] tol;
        logic [LIM_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [E_W-1:0] sum;
        logic           pos;
    } t_add_res;

endpackage

@@ design/rapx_cfg.sv @@
// Configuration registers: tolerance and step limit.
module rapx_cfg import rapx_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [TOL_W-1:0] r_tol;
    logic [LIM_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOL:   r_tol   <= i_cfg_data[TOL_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.tol   = r_tol;
    assign o_cfg.limit = r_limit;

endmodule

@@ design/rapx_addu.sv @@
// Shared wide adder with a positive flag.
module rapx_addu import rapx_pkg::*; (
    input  logic [E_W-1:0] i_a,
    input  logic [E_W-1:0] i_b,
    input  logic           i_cin,
    output t_add_res       o_res
);

    logic [E_W-1:0] sum;

    assign sum       = i_a + i_b + E_W'(i_cin);
    assign o_res.sum = sum;
    assign o_res.pos = !sum[E_W-1] && (|sum);

endmodule

@@ design/rational_approximation_search_core.sv @@
// Stern-Brocot rational approximation of a signed Q32.32 value within a set tolerance.
// Each request takes N mediant steps, where N is 0 when the fraction lies within tolerance
// of 0 or 1 and is otherwise at most the step limit, which counts as one when set to zero.
// Each mediant step passes through S_SUMP and S_SUMN, where the one shared 66-bit adder
// sums the upper and lower error terms of the two bounding fractions; the same adder
// also negates a negative input in S_NEG. A new request is taken only while the core is
// idle; a finished result may still wait in the output register at that time.
module rational_approximation_search_core import rapx_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [IN_W-1:0]      i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [NUM_W-1:0]     o_numerator,
    output logic [DEN_W-1:0]     o_denominator,
    output logic [ST_W-1:0]      o_status,
    output logic [LIM_W-1:0]     o_steps_used,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg     cfg;
    t_add_res add;
    t_state   r_state, n_state;

    logic [E_W-1:0]    add_a, add_b;
    logic              add_cin;

    logic [IN_W-1:0]   r_raw;
    logic              r_neg;
    logic [IP_W-1:0]   r_ip;
    logic [F_W-1:0]    r_f;
    logic [D_W-1:0]    r_m, r_d;
    logic [D_W-1:0]    r_lo_n, r_lo_d, r_hi_n, r_hi_d;
    logic [E_W-1:0]    r_ep, r_ep_lo, r_ep_hi, r_en_lo, r_en_hi;
    logic [LIM_W-1:0]  r_steps;
    t_status           r_status;
    logic              r_sat;
    logic [PROD_W-1:0] r_prod;

    logic              r_o_valid;
    logic [NUM_W-1:0]  r_o_num;
    logic [DEN_W-1:0]  r_o_den;
    t_status           r_o_status;
    logic [LIM_W-1:0]  r_o_steps;

    logic              accept, out_free;
    logic [D_W-1:0]    fp, fm;
    logic              to_zero, to_one;
    logic [E_W-1:0]    one_e;
    logic [LIM_W-1:0]  limit_eff;
    logic              go_hi, go_lo, hit_limit;
    logic [PROD_W:0]   fin_sum;
    logic              over;
    logic [DEN_W-1:0]  nmag, den_out;
    logic [NUM_W-1:0]  num_out;

    rapx_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rapx_addu u_addu (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_cin (add_cin),
        .o_res (add)
    );

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    assign fp      = {1'b0, r_f} + {1'b0, cfg.tol};
    assign fm      = {1'b0, r_f} - {1'b0, cfg.tol};
    assign to_zero = (r_f <= cfg.tol);
    assign to_one  = fp[D_W-1] && (|fp[D_W-2:0]);
    assign one_e   = E_W'(1) << F_W;

    assign limit_eff = (cfg.limit == '0) ? LIM_W'(1) : cfg.limit;
    assign go_hi     = r_ep[E_W-1];
    assign go_lo     = !go_hi && add.pos;
    assign hit_limit = (r_steps >= limit_eff);

    assign fin_sum = {1'b0, r_prod} + (PROD_W+1)'(r_m);
    assign over    = r_sat || (|fin_sum[PROD_W:DEN_W]);
    assign nmag    = over ? {DEN_W{1'b1}} : fin_sum[DEN_W-1:0];
    assign den_out = (|r_d[D_W-1:DEN_W]) ? {DEN_W{1'b1}} : r_d[DEN_W-1:0];
    assign num_out = r_neg ? (NUM_W'(0) - {1'b0, nmag}) : {1'b0, nmag};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (r_state)
            S_NEG: begin
                add_a   = E_W'(r_neg ? ~r_raw : r_raw);
                add_cin = r_neg;
            end
            S_SUMP: begin
                add_a = r_ep_lo;
                add_b = r_ep_hi;
            end
            S_SUMN: begin
                add_a = r_en_lo;
                add_b = r_en_hi;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = S_NEG;
                end
            end
            S_NEG:   n_state = S_CLASS;
            S_CLASS: n_state = (to_zero || to_one) ? S_MUL : S_SUMP;
            S_SUMP:  n_state = S_SUMN;
            S_SUMN: begin
                if ((!go_hi && !go_lo) || hit_limit) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SUMP;
                end
            end
            S_MUL:   n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_raw <= i_value;
                    r_neg <= i_value[IN_W-1];
                end
            end
            S_NEG: begin
                r_ip <= add.sum[IN_W-1:FRAC_BITS];
                r_f  <= F_W'(add.sum[FRAC_BITS-1:0]) << (F_W - FRAC_BITS);
            end
            S_CLASS: begin
                r_steps  <= '0;
                r_status <= ST_OK;
                r_d      <= D_W'(1);
                r_m      <= (!to_zero && to_one) ? D_W'(1) : D_W'(0);
                r_lo_n   <= D_W'(0);
                r_lo_d   <= D_W'(1);
                r_hi_n   <= D_W'(1);
                r_hi_d   <= D_W'(1);
                r_ep_lo  <= E_W'(fp);
                r_ep_hi  <= E_W'(fp) - one_e;
                r_en_lo  <= E_W'(fm);
                r_en_hi  <= E_W'(fm) - one_e;
            end
            S_SUMP: begin
                r_ep    <= add.sum;
                r_m     <= r_lo_n + r_hi_n;
                r_d     <= r_lo_d + r_hi_d;
                r_steps <= r_steps + LIM_W'(1);
            end
            S_SUMN: begin
                if (go_hi) begin
                    r_hi_n  <= r_m;
                    r_hi_d  <= r_d;
                    r_ep_hi <= r_ep;
                    r_en_hi <= add.sum;
                end else if (go_lo) begin
                    r_lo_n  <= r_m;
                    r_lo_d  <= r_d;
                    r_ep_lo <= r_ep;
                    r_en_lo <= add.sum;
                end
                if ((go_hi || go_lo) && hit_limit) begin
                    r_status <= ST_LIMIT;
                end
            end
            S_MUL: begin
                r_sat  <= (|r_ip[IP_W-1:DEN_W]) || (|r_d[D_W-1:DEN_W]);
                r_prod <= r_ip[DEN_W-1:0] * r_d[DEN_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_num    <= num_out;
            r_o_den    <= den_out;
            r_o_status <= over ? ST_SAT : r_status;
            r_o_steps  <= r_steps;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_numerator   = r_o_num;
    assign o_denominator = r_o_den;
    assign o_status      = r_o_status;
    assign o_steps_used  = r_o_steps;

endmodule

@@ sim/tb.sv @@
// Self-checking bench for the Stern-Brocot rational approximation core.
module tb;
    import rapx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_SEGMENTS = 9;
    localparam int          SEGMENT_ITEMS   = 150;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          LIMIT_CYCLES    = 2_500_000;
    localparam logic [63:0] ONE_Q           = 64'h0000_0001_0000_0000;
    localparam logic [63:0] DEN_MAX         = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        t_status          st;
        logic [LIM_W-1:0] steps;
    } t_approx;

    typedef struct packed {
        logic [TOL_W-1:0] tol;
        logic [LIM_W-1:0] lim;
        logic [IN_W-1:0]  value;
        logic             typed;
        t_approx          want;
    } t_row;

    localparam t_approx NO_WANT = '0;
    localparam int      DIR_N   = 22;

    localparam t_row DIRECTED [DIR_N] = '{
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0000_0000_0000, 1'b1,
          '{32'd0, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0001_0000_0000, 1'b1,
          '{32'd1, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'hFFFF_FFFF_0000_0000, 1'b1,
          '{32'hFFFF_FFFF, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0000_8000_0000, 1'b1,
          '{32'd1, 31'd2, ST_OK, 16'd1}},
        '{TOL_RESET, LIMIT_RESET, 64'hFFFF_FFFF_8000_0000, 1'b1,
          '{32'hFFFF_FFFF, 31'd2, ST_OK, 16'd1}},
        '{TOL_RESET, LIMIT_RESET, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
          '{32'h7FFF_FFFF, 31'd1, ST_SAT, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h8000_0000_0000_0000, 1'b1,
          '{32'h8000_0001, 31'd1, ST_SAT, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0000_0000_0001, 1'b1,
          '{32'd0, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{32'd0, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0000_FFFF_FFFF, 1'b1,
          '{32'd1, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0003_0000_A7C6, 1'b1,
          '{32'd3, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0003_0000_A7C7, 1'b0, NO_WANT},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0002_FFFF_583B, 1'b1,
          '{32'd3, 31'd1, ST_OK, 16'd0}},
        '{TOL_RESET, LIMIT_RESET, 64'h0000_0000_FFFF_583A, 1'b0, NO_WANT},
        '{TOL_RESET, 16'd1, 64'h0000_0000_5555_5555, 1'b1,
          '{32'd1, 31'd2, ST_LIMIT, 16'd1}},
        '{TOL_RESET, 16'd0, 64'h0000_0000_5555_5555, 1'b1,
          '{32'd1, 31'd2, ST_LIMIT, 16'd1}},
        '{32'hFFFF_FFFF, 16'd0, 64'h0000_0003_8000_0000, 1'b1,
          '{32'd3, 31'd1, ST_OK, 16'd0}},
        '{32'hFFFF_FFFF, 16'd0, 64'hFFFF_FFFC_8000_0000, 1'b1,
          '{32'hFFFF_FFFD, 31'd1, ST_OK, 16'd0}},
        '{32'd0, LIMIT_RESET, 64'h0000_0000_4000_0000, 1'b1,
          '{32'd1, 31'd4, ST_OK, 16'd3}},
        '{32'd0, LIMIT_RESET, 64'hFFFF_FFFA_C000_0000, 1'b1,
          '{32'hFFFF_FFEB, 31'd4, ST_OK, 16'd3}},
        '{32'd0, 16'hFFFF, 64'h0000_0000_0000_0001, 1'b1,
          '{32'd1, 31'd65536, ST_LIMIT, 16'hFFFF}},
        '{32'd0, 16'hFFFF, 64'h0000_0000_9E37_79B9, 1'b0, NO_WANT}
    };

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    logic [IN_W-1:0]      i_value    = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    logic [NUM_W-1:0]     o_numerator;
    logic [DEN_W-1:0]     o_denominator;
    logic [ST_W-1:0]      o_status;
    logic [LIM_W-1:0]     o_steps_used;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_TOL;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    t_approx          pending_fractions [$];
    t_approx          got_exp;
    logic [TOL_W-1:0] cur_tol = TOL_RESET;
    logic [LIM_W-1:0] cur_lim = LIMIT_RESET;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_ticket = 0;
    int               hold_taken = 0;
    int               hold_left = 0;
    int               cycles = 0;
    int               fails = 0;
    int               results_seen = 0;
    int               capped_seen = 0;
    int               saturated_seen = 0;
    int               directed_sent = 0;
    int               random_sent = 0;
    int               settings_used = 1;

    rational_approximation_search_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator),
        .o_status      (o_status),
        .o_steps_used  (o_steps_used),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sat_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:64] != 64'd0) ? '1 : p[63:0];
    endfunction

    function automatic t_approx approximate(input logic [IN_W-1:0] raw,
                                            input logic [TOL_W-1:0] tol_reg,
                                            input logic [LIM_W-1:0] lim_reg);
        logic        neg;
        logic [63:0] mag, ip, f, tol, m, d, lo_n, lo_d, hi_n, hi_d;
        logic [63:0] up, lw, mm, nmag, cap, steps;
        logic        done;
        t_status     st;
        t_approx     r;
        neg   = raw[IN_W-1];
        mag   = neg ? -raw : raw;
        ip    = mag >> FRAC_BITS;
        f     = (mag & ((64'd1 << FRAC_BITS) - 64'd1)) << (F_W - FRAC_BITS);
        tol   = {32'd0, tol_reg};
        m     = 64'd0;
        d     = 64'd1;
        steps = 64'd0;
        st    = ST_OK;
        if (f <= tol) begin
            m = 64'd0;
        end else if (f + tol > ONE_Q) begin
            m = 64'd1;
        end else begin
            lo_n = 64'd0;
            lo_d = 64'd1;
            hi_n = 64'd1;
            hi_d = 64'd1;
            cap  = (lim_reg == '0) ? 64'd1 : {48'd0, lim_reg};
            done = 1'b0;
            while (!done) begin
                m     = lo_n + hi_n;
                d     = lo_d + hi_d;
                steps = steps + 64'd1;
                up    = sat_product(f + tol, d);
                lw    = sat_product(f - tol, d);
                mm    = sat_product(m, ONE_Q);
                if (up < mm) begin
                    hi_n = m;
                    hi_d = d;
                end else if (lw > mm) begin
                    lo_n = m;
                    lo_d = d;
                end else begin
                    done = 1'b1;
                end
                if (!done && steps >= cap) begin
                    st   = ST_LIMIT;
                    done = 1'b1;
                end
            end
        end
        if (ip > DEN_MAX || d > DEN_MAX || ip * d + m > DEN_MAX) begin
            st   = ST_SAT;
            nmag = DEN_MAX;
            if (d > DEN_MAX) begin
                d = DEN_MAX;
            end
        end else begin
            nmag = ip * d + m;
        end
        r.num   = NUM_W'(neg ? -nmag : nmag);
        r.den   = DEN_W'(d);
        r.st    = st;
        r.steps = LIM_W'(steps);
        return r;
    endfunction

    function automatic logic [IN_W-1:0] draw_value(input logic [TOL_W-1:0] tol);
        logic [31:0]     ip, fr, q, p;
        logic [IN_W-1:0] v;
        ip = $urandom_range(0, 1000);
        fr = $urandom;
        case ($urandom_range(0, 5))
            0: ip = $urandom;
            1: fr = $urandom_range(0, 255) << $urandom_range(0, 24);
            2: fr = (($urandom_range(0, 1) == 0) ? tol : -tol) + $urandom_range(0, 2) - 32'd1;
            3: begin
                q  = $urandom_range(2, 60);
                p  = $urandom_range(1, q - 1);
                fr = 32'({p, 32'd0} / {32'd0, q}) + $urandom_range(0, 2) - 32'd1;
            end
            4: ip = 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: ip = $urandom_range(32'h0010_0000, 32'h0400_0000);
        endcase
        v = {ip, fr};
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_fractions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [TOL_W-1:0] tol, input logic [LIM_W-1:0] lim);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TOL;
        i_cfg_data <= tol;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= {16'd0, lim};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_tol = tol;
        cur_lim = lim;
        settings_used++;
    endtask

    task automatic offer_value(input logic [IN_W-1:0] v, input logic typed, input t_approx want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_fractions.push_back(typed ? want : approximate(v, cur_tol, cur_lim));
    endtask

    // receiver side: random stall, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_ticket != hold_taken) begin
            hold_taken = hold_ticket;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_fractions.size() == 0) begin
                $error("unexpected result: numerator %0d denominator %0d",
                       $signed(o_numerator), o_denominator);
                fails++;
            end else begin
                got_exp = pending_fractions.pop_front();
                if (o_numerator !== got_exp.num) begin
                    $error("numerator: expected %0d, got %0d",
                           $signed(got_exp.num), $signed(o_numerator));
                    fails++;
                end
                if (o_denominator !== got_exp.den) begin
                    $error("denominator: expected %0d, got %0d", got_exp.den, o_denominator);
                    fails++;
                end
                if (o_status !== got_exp.st) begin
                    $error("status: expected %0d, got %0d", got_exp.st, o_status);
                    fails++;
                end
                if (o_steps_used !== got_exp.steps) begin
                    $error("steps_used: expected %0d, got %0d", got_exp.steps, o_steps_used);
                    fails++;
                end
                results_seen++;
                if (got_exp.st == ST_LIMIT) capped_seen++;
                if (got_exp.st == ST_SAT) saturated_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_row             row;
        logic [TOL_W-1:0] tol;
        logic [LIM_W-1:0] lim;
        int               idx;
        int               seg;
        send_idle_pct = 19;
        recv_idle_pct = 76;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < DIR_N; idx++) begin
            row = DIRECTED[idx];
            if (row.tol != cur_tol || row.lim != cur_lim) begin
                set_config(row.tol, row.lim);
            end
            offer_value(row.value, row.typed, row.want);
            directed_sent++;
        end

        for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 76;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg)
                0: begin
                    tol = TOL_RESET;
                    lim = 16'd256;
                end
                1: begin
                    tol = $urandom_range(1, 1000);
                    lim = 16'd64;
                end
                2: begin
                    tol = 32'd0;
                    lim = 16'd24;
                end
                3: begin
                    tol = $urandom_range(32'h0010_0000, 32'h8000_0000);
                    lim = $urandom_range(1, 8);
                end
                4: begin
                    tol = 32'hFFFF_FFFF;
                    lim = 16'hFFFF;
                end
                5: begin
                    tol = 32'd1;
                    lim = 16'd48;
                end
                6: begin
                    tol = $urandom;
                    lim = $urandom_range(1, 200);
                end
                7: begin
                    tol = TOL_RESET;
                    lim = 16'd1;
                end
                default: begin
                    tol = $urandom_range(1, 65536);
                    lim = 16'd300;
                end
            endcase
            set_config(tol, lim);
            // hold the result side long enough to back up the input
            if (seg == 1) hold_ticket <= hold_ticket + 1;
            for (idx = 0; idx < SEGMENT_ITEMS; idx++) begin
                offer_value(draw_value(cur_tol), 1'b0, NO_WANT);
                random_sent++;
            end
        end

        drain_results();
        $display("sent %0d directed and %0d random requests across %0d register settings",
                 directed_sent, random_sent, settings_used);
        $display("checked %0d results: %0d stopped at the step cap, %0d saturated",
                 results_seen, capped_seen, saturated_seen);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
